// ===== hw/rtl/hvn3_pkg.sv =====
// Package for the 3D value noise core: operation codes, widths and defaults.
// No dependencies.
`default_nettype none
package hvn3_pkg;
   localparam int TableSize = 256;
   localparam int FractionBitsDefault = 16;
   localparam int CoordWidth = 32;
   localparam int ValueWidth = 16;
   localparam int IndexWidth = 8;

   typedef enum logic [2:0] {
      OP_EVAL    = 3'd0,
      OP_PERM_X  = 3'd1,
      OP_PERM_Y  = 3'd2,
      OP_PERM_Z  = 3'd3,
      OP_VALUE   = 3'd4
   } op_type;
endpackage
`default_nettype wire

// ===== hw/rtl/hermite_value_noise_3d_core.sv =====
// 3D value noise core: table loading, Hermite smoothing, hashing, trilinear blend.
// Depends on hvn3_pkg.
//
// Channel  Dir  Fields (tdata low bit up)
// req      in   op[2:0], coord_x[34:3], coord_y[66:35], coord_z[98:67],
//               entry_index[106:99], entry_value[122:107]
// rsp      out  noise_value[15:0]
//
// One request can enter in every cycle while the pipeline advances, and the
// pipeline advances as a whole when the output register is empty or being
// taken.  Permutation writes update their tables on acceptance; a value write
// lands one pipeline step later, so an earlier evaluate still reads the old
// entry.  Writes yield no result.
// Reset is synchronous and clears only the valid bits; the tables hold
// undefined data until written.
`default_nettype none
module hermite_value_noise_3d_core
   import hvn3_pkg::*;
#(
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata, // op, coord_x, coord_y, coord_z, entry_index, entry_value
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata  // noise_value
);
   localparam int AW = $clog2(TableSize);
   localparam int FB = FRACTION_BITS;
   localparam int NS = 6;
   localparam int NCOPY = 4;

   logic [2:0]            op;
   logic signed [31:0]    coord [3];
   logic [IndexWidth-1:0] entry_index;
   logic [ValueWidth-1:0] entry_value;
   assign op          = req_tdata[2:0];
   assign coord[0]    = req_tdata[34:3];
   assign coord[1]    = req_tdata[66:35];
   assign coord[2]    = req_tdata[98:67];
   assign entry_index = req_tdata[106:99];
   assign entry_value = req_tdata[122:107];

   logic adv, acc;
   logic [NS-1:0] vld_ff, vld_in;
   logic          out_vld_ff;
   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign acc = req_tvalid && req_tready;

   // Tables. The value table is kept in four copies so each copy serves two reads.
   logic [AW-1:0] perm_x [TableSize];
   logic [AW-1:0] perm_y [TableSize];
   logic [AW-1:0] perm_z [TableSize];
   logic [ValueWidth-1:0] lat [NCOPY][TableSize];

   always_ff @(posedge clock) begin
      if (acc) begin
         unique case (op)
            OP_PERM_X: perm_x[entry_index[AW-1:0]] <= entry_value[AW-1:0];
            OP_PERM_Y: perm_y[entry_index[AW-1:0]] <= entry_value[AW-1:0];
            OP_PERM_Z: perm_z[entry_index[AW-1:0]] <= entry_value[AW-1:0];
            default: ;
         endcase
      end
   end

   logic                  lw_vld_ff;
   logic [AW-1:0]         lw_idx_ff;
   logic [ValueWidth-1:0] lw_val_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_vld_ff <= 1'b0;
      end else if (adv) begin
         lw_vld_ff <= acc && (op == OP_VALUE);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         lw_idx_ff <= entry_index[AW-1:0];
         lw_val_ff <= entry_value;
      end
   end
   always_ff @(posedge clock) begin
      if (adv && lw_vld_ff) begin
         for (int c = 0; c < NCOPY; c++)
            lat[c][lw_idx_ff] <= lw_val_ff;
      end
   end

   // Stage 1: split coordinates.
   logic [AW-1:0] c1_ff [3];
   logic [FB-1:0] f1_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            c1_ff[a] <= coord[a][FB +: AW];
            f1_ff[a] <= coord[a][FB-1:0];
         end
      end
   end

   // Stage 2: f squared; read permutation entries for i and i+1.
   logic [FB-1:0] f2_ff [3], fsq_ff [3];
   logic [AW-1:0] px_ff [2], py_ff [2], pz_ff [2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            f2_ff[a]  <= f1_ff[a];
            fsq_ff[a] <= FB'(({{FB{1'b0}}, f1_ff[a]} * {{FB{1'b0}}, f1_ff[a]}) >> FB);
         end
         px_ff[0] <= perm_x[c1_ff[0]];
         px_ff[1] <= perm_x[AW'(c1_ff[0] + AW'(1))];
         py_ff[0] <= perm_y[c1_ff[1]];
         py_ff[1] <= perm_y[AW'(c1_ff[1] + AW'(1))];
         pz_ff[0] <= perm_z[c1_ff[2]];
         pz_ff[1] <= perm_z[AW'(c1_ff[2] + AW'(1))];
      end
   end

   function automatic logic [FB-1:0] hermite(input logic [FB-1:0] f,
         input logic [FB-1:0] fsq);
      logic [FB+1:0]   k;
      logic [2*FB+1:0] p;
      k = ((FB+2)'(3) << FB) - (FB+2)'({f, 1'b0});
      p = (2*FB+2)'(fsq) * (2*FB+2)'(k);
      return FB'(p >> FB);
   endfunction

   // Stage 3: smoothed weight; read eight corner values (index = x + 2y + 4z).
   logic [FB-1:0] s3_ff [3];
   logic [ValueWidth-1:0] v3_ff [8];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++)
            s3_ff[a] <= hermite(f2_ff[a], fsq_ff[a]);
         for (int k = 0; k < 8; k++)
            v3_ff[k] <= lat[k >> 1][px_ff[k & 1] ^ py_ff[(k >> 1) & 1] ^ pz_ff[(k >> 2) & 1]];
      end
   end

   // Stages 4..6: blend x, y, z.
   function automatic logic [ValueWidth-1:0] lerp(input logic [ValueWidth-1:0] a,
         input logic [ValueWidth-1:0] b, input logic [FB-1:0] t);
      logic [ValueWidth+FB+1:0] p;
      p = (ValueWidth+FB+2)'(a) * (ValueWidth+FB+2)'(((FB+1)'(1) << FB) - (FB+1)'(t))
        + (ValueWidth+FB+2)'(b) * (ValueWidth+FB+2)'(t);
      return ValueWidth'(p >> FB);
   endfunction

   logic [ValueWidth-1:0] x4_ff [4], y5_ff [2], z6_ff;
   logic [FB-1:0] sy4_ff, sz4_ff, sz5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++)
            x4_ff[k] <= lerp(v3_ff[2*k], v3_ff[2*k+1], s3_ff[0]);
         sy4_ff <= s3_ff[1];
         sz4_ff <= s3_ff[2];
         y5_ff[0] <= lerp(x4_ff[0], x4_ff[1], sy4_ff);
         y5_ff[1] <= lerp(x4_ff[2], x4_ff[3], sy4_ff);
         sz5_ff <= sz4_ff;
         z6_ff <= lerp(y5_ff[0], y5_ff[1], sz5_ff);
      end
   end

   // Valid chain and output register.
   logic [ValueWidth-1:0] out_ff;
   always_comb begin
      vld_in = {vld_ff[NS-2:0], acc && (op == OP_EVAL)};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
         out_vld_ff <= vld_ff[NS-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) out_ff <= z6_ff;
   end
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
endmodule
`default_nettype wire
